// ===== hdl/dpo_pkg.sv =====
// Shared types, widths and calendar tables for the date period overlap pipeline.
`default_nettype none

package dpo_pkg;

    localparam int DayW   = 5;
    localparam int MonW   = 4;
    localparam int YearW  = 14;
    localparam int DnW    = 23;   // day number of year 16383, Dec 31 still fits
    localparam int QW     = 8;    // year / 100 for a 14-bit year
    localparam int CumW   = 9;    // days before a month, at most 334
    localparam int CntW   = 15;
    localparam int MaxYrW = 16;

    // floor(x / 100) = (x * 5243) >> 19, exact for x < 16384
    localparam int RecipHundred = 5243;
    localparam int RecipShift   = 19;
    localparam int ProdW        = YearW + 13;

    localparam logic [CntW-1:0] CountMax = '1;

    localparam logic [MonW-1:0] MonFeb = 4'd2;

    // one decoded date, as seen at the end of the day-number stages
    typedef struct packed {
        logic           ok;
        logic [DnW-1:0] dn;
    } t_date_res;

    // days in each month of a common year; 0 for a month code outside 1..12
    function automatic logic [DayW-1:0] f_month_len(input logic [MonW-1:0] m);
        logic [DayW-1:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // days of a common year that come before the first of month m
    function automatic logic [CumW-1:0] f_cum_days(input logic [MonW-1:0] m);
        logic [CumW-1:0] cum;
        unique case (m)
            4'd1:    cum = 9'd0;
            4'd2:    cum = 9'd31;
            4'd3:    cum = 9'd59;
            4'd4:    cum = 9'd90;
            4'd5:    cum = 9'd120;
            4'd6:    cum = 9'd151;
            4'd7:    cum = 9'd181;
            4'd8:    cum = 9'd212;
            4'd9:    cum = 9'd243;
            4'd10:   cum = 9'd273;
            4'd11:   cum = 9'd304;
            4'd12:   cum = 9'd334;
            default: cum = 9'd0;
        endcase
        return cum;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/dpo_date_num.sv =====
// Two-stage date check and day-number conversion for one date.
`default_nettype none

module dpo_date_num #(
    parameter int MAX_YEAR = 9999
) (
    input  wire logic                    i_clk,
    input  wire logic [1:0]              i_en,     // load enables of stage 1 and 2
    input  wire logic [dpo_pkg::DayW-1:0]  i_day,
    input  wire logic [dpo_pkg::MonW-1:0]  i_month,
    input  wire logic [dpo_pkg::YearW-1:0] i_year,
    output dpo_pkg::t_date_res           o_res
);
    import dpo_pkg::*;

    localparam logic [MaxYrW-1:0] MaxYearV = MaxYrW'(MAX_YEAR);

    // stage 1: divisions by constant, (year-1)*365, month tables
    logic [YearW-1:0] w_p;
    logic [ProdW-1:0] w_prod_p;
    logic [ProdW-1:0] w_prod_y;

    logic [DayW-1:0]  r_day;
    logic [MonW-1:0]  r_mon;
    logic [YearW-1:0] r_year;
    logic [DnW-1:0]   r_p365;
    logic [YearW-3:0] r_p4;
    logic [QW-1:0]    r_qp;
    logic [QW-1:0]    r_qy;
    logic [CumW-1:0]  r_cum;
    logic [DayW-1:0]  r_mlen;
    logic             r_yok;

    assign w_p      = i_year - YearW'(1);
    assign w_prod_p = ProdW'(w_p) * ProdW'(RecipHundred);
    assign w_prod_y = ProdW'(i_year) * ProdW'(RecipHundred);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_day  <= i_day;
            r_mon  <= i_month;
            r_year <= i_year;
            r_p365 <= DnW'(w_p) * DnW'(365);
            r_p4   <= w_p[YearW-1:2];
            r_qp   <= w_prod_p[RecipShift +: QW];
            r_qy   <= w_prod_y[RecipShift +: QW];
            r_cum  <= f_cum_days(i_month);
            r_mlen <= f_month_len(i_month);
            r_yok  <= (i_year != '0) && ({{(MaxYrW-YearW){1'b0}}, i_year} <= MaxYearV);
        end
    end

    // stage 2: leap year, validity, day number sum
    logic            w_leap;
    logic [DayW-1:0] w_dim;
    logic            w_ok;
    logic [DnW-1:0]  w_dn;

    always_comb begin
        // divisible by 4, and not a century unless the century count is a multiple of 4
        w_leap = (r_year[1:0] == 2'b00)
              && ((r_year != (YearW'(r_qy) * YearW'(100))) || (r_qy[1:0] == 2'b00));
        w_dim  = (r_mon == MonFeb) ? (r_mlen + DayW'(w_leap)) : r_mlen;
        w_ok   = r_yok && (r_mlen != '0) && (r_day != '0) && (r_day <= w_dim);
        w_dn   = r_p365 + DnW'(r_p4) - DnW'(r_qp) + DnW'(r_qp[QW-1:2]) + DnW'(r_cum)
               + DnW'(w_leap && (r_mon > MonFeb)) + DnW'(r_day);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            o_res.ok <= w_ok;
            o_res.dn <= w_dn;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/dpo_overlap.sv =====
// Three-stage period length, period selection and overlap count with saturation.
`default_nettype none

module dpo_overlap (
    input  wire logic                     i_clk,
    input  wire logic [2:0]               i_en,    // load enables of stages 3, 4, 5
    input  wire dpo_pkg::t_date_res       i_s1,
    input  wire dpo_pkg::t_date_res       i_e1,
    input  wire dpo_pkg::t_date_res       i_s2,
    input  wire dpo_pkg::t_date_res       i_e2,
    output logic [dpo_pkg::CntW-1:0]      o_count,
    output logic                          o_saturated,
    output logic                          o_bad_date
);
    import dpo_pkg::*;

    // stage 3: period lengths
    logic [DnW-1:0] r_s1, r_e1, r_s2, r_e2, r_len1, r_len2;
    logic           r_ok3;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_s1   <= i_s1.dn;
            r_e1   <= i_e1.dn;
            r_s2   <= i_s2.dn;
            r_e2   <= i_e2.dn;
            r_len1 <= (i_s1.dn < i_e1.dn) ? (i_e1.dn - i_s1.dn) : '0;
            r_len2 <= (i_s2.dn < i_e2.dn) ? (i_e2.dn - i_s2.dn) : '0;
            r_ok3  <= i_s1.ok && i_e1.ok && i_s2.ok && i_e2.ok;
        end
    end

    // stage 4: pick the shorter period (period two on a tie), window bounds
    logic           w_a_is1;
    logic [DnW-1:0] w_sa, w_ea, w_sb;
    logic [DnW:0]   w_eb1;
    logic [DnW:0]   r_lo, r_hi;
    logic           r_ok4;

    always_comb begin
        w_a_is1 = r_len1 < r_len2;
        w_sa    = w_a_is1 ? r_s1 : r_s2;
        w_ea    = w_a_is1 ? r_e1 : r_e2;
        w_sb    = w_a_is1 ? r_s2 : r_s1;
        w_eb1   = {1'b0, (w_a_is1 ? r_e2 : r_e1)} + (DnW+1)'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_lo  <= {1'b0, ((w_sa > w_sb) ? w_sa : w_sb)};
            r_hi  <= ({1'b0, w_ea} < w_eb1) ? {1'b0, w_ea} : w_eb1;
            r_ok4 <= r_ok3;
        end
    end

    // stage 5: count, saturate, mask on a bad date
    logic [DnW:0] w_cnt;
    logic         w_sat;

    always_comb begin
        w_cnt = (r_hi > r_lo) ? (r_hi - r_lo) : '0;
        w_sat = w_cnt > (DnW+1)'(CountMax);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            o_bad_date  <= !r_ok4;
            o_saturated <= r_ok4 && w_sat;
            if (!r_ok4) begin
                o_count <= '0;
            end else if (w_sat) begin
                o_count <= CountMax;
            end else begin
                o_count <= w_cnt[CntW-1:0];
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/date_period_overlap_days.sv =====
// Top level: overlap day count of two Gregorian date periods, five-stage pipeline.
//
//  channel | dir | tdata                                   | tuser
//  --------+-----+-----------------------------------------+-------------------------
//  s_axis  | in  | 12 date fields, 92 bits used of 96      | -
//  m_axis  | out | overlap_days, 15 bits used of 16        | saturated, bad_date
//
// One transfer in per cycle unless m_axis_tready holds the pipe, one result per
// transfer (two stages of day-number conversion, then length, selection, count).
// Throughput is set by nothing but the downstream tready: each stage loads
// whenever it is empty or its successor moves, so bubbles collapse.
// Reset (synchronous, active low) clears only the stage valid bits.
// A stall on m_axis holds the full stages; no transfer is lost or repeated.
`default_nettype none

module date_period_overlap_days #(
    parameter int MAX_YEAR = 9999
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [4:0] start1_day, [8:5] start1_month, [22:9] start1_year,
    // [27:23] end1_day, [31:28] end1_month, [45:32] end1_year,
    // [50:46] start2_day, [54:51] start2_month, [68:55] start2_year,
    // [73:69] end2_day, [77:74] end2_month, [91:78] end2_year, [95:92] zero
    input  wire logic [95:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [14:0] overlap_days, [15] zero
    output logic [15:0]      m_axis_tdata,
    // [0] saturated, [1] bad_date
    output logic [1:0]       m_axis_tuser
);
    import dpo_pkg::*;

    localparam int Stages = 5;
    localparam int DateW  = DayW + MonW + YearW;

    // valid chain and per-stage load enables
    logic [Stages-1:0] r_valid;
    logic [Stages-1:0] w_en;

    always_comb begin
        w_en[Stages-1] = !r_valid[Stages-1] || m_axis_tready;
        for (int k = Stages - 2; k >= 0; k--) begin
            w_en[k] = !r_valid[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_en[0]) begin
                r_valid[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < Stages; k++) begin
                if (w_en[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    assign s_axis_tready = w_en[0];
    assign m_axis_tvalid = r_valid[Stages-1];

    // four date converters, one per date of the transfer
    t_date_res w_res [4];

    for (genvar g = 0; g < 4; g++) begin : g_date
        dpo_date_num #(
            .MAX_YEAR (MAX_YEAR)
        ) u_date (
            .i_clk   (i_clk),
            .i_en    (w_en[1:0]),
            .i_day   (s_axis_tdata[g*DateW +: DayW]),
            .i_month (s_axis_tdata[g*DateW + DayW +: MonW]),
            .i_year  (s_axis_tdata[g*DateW + DayW + MonW +: YearW]),
            .o_res   (w_res[g])
        );
    end

    logic [CntW-1:0] w_count;
    logic            w_saturated;
    logic            w_bad_date;

    dpo_overlap u_overlap (
        .i_clk       (i_clk),
        .i_en        (w_en[4:2]),
        .i_s1        (w_res[0]),
        .i_e1        (w_res[1]),
        .i_s2        (w_res[2]),
        .i_e2        (w_res[3]),
        .o_count     (w_count),
        .o_saturated (w_saturated),
        .o_bad_date  (w_bad_date)
    );

    assign m_axis_tdata = {1'b0, w_count};
    assign m_axis_tuser = {w_bad_date, w_saturated};

endmodule

`default_nettype wire

// ===== hdl/dpo_checker.sv =====
// Port-level checker for the overlap pipeline and its bind to the top level.
`default_nettype none

module dpo_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [95:0] s_axis_tdata,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [15:0] m_axis_tdata,
    input  wire logic [1:0]  m_axis_tuser
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result changed while stalled");

    // an empty output stage means the whole pipeline can move
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |->
            (m_axis_tdata == 16'd0 && !m_axis_tuser[0]))
        else $error("bad date with nonzero count");

    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == 16'h7fff))
        else $error("saturated count not at maximum");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind date_period_overlap_days dpo_checker u_dpo_checker (.*);

`default_nettype wire

// ===== test/date_period_overlap_days_test.sv =====
// Self-checking testbench for date_period_overlap_days: stream driver, monitor, day-count model.
`timescale 1ns / 1ps

module date_period_overlap_days_test;

    import dpo_pkg::*;

    localparam int MaxYear  = 9999;
    localparam int CountCap = 32767;

    // one calendar date, day in the low bits, as it sits in tdata
    typedef struct packed {
        logic [YearW-1:0] year;
        logic [MonW-1:0]  month;
        logic [DayW-1:0]  day;
    } t_cal_date;

    // [0] start1, [1] end1, [2] start2, [3] end2 -- same order as tdata
    typedef t_cal_date [3:0] t_date_quad;

    typedef struct {
        logic [CntW-1:0] days;
        logic            sat;
        logic            bad;
    } t_overlap_res;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [4:0] start1_day .. [91:78] end2_year, [95:92] zero
    logic [95:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [14:0] overlap_days, [15] zero
    logic [15:0] m_axis_tdata;
    // [0] saturated, [1] bad_date
    logic [1:0]  m_axis_tuser;

    t_date_quad   pending_items[$];
    t_overlap_res expected_counts[$];

    int  send_idle_pct   = 0;
    int  recv_idle_pct   = 0;
    int  error_count     = 0;
    int  stall_left      = 0;
    bit  long_stall_req  = 1'b0;
    bit  long_stall_done = 1'b0;
    logic sent_fire      = 1'b0;

    always #6 i_clk = ~i_clk;

    date_period_overlap_days #(
        .MAX_YEAR(MaxYear)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    // ------------------------------------------------------------------
    // Calendar model
    // ------------------------------------------------------------------

    function automatic bit is_leap(int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int month_days(int m, int y);
        case (m)
            2:                      return is_leap(y) ? 29 : 28;
            4, 6, 9, 11:            return 30;
            1, 3, 5, 7, 8, 10, 12:  return 31;
            default:                return 0;
        endcase
    endfunction

    function automatic bit date_valid(t_cal_date dt);
        if (dt.year < 1 || dt.year > MaxYear) return 1'b0;
        if (dt.month < 1 || dt.month > 12) return 1'b0;
        return (dt.day >= 1) && (dt.day <= month_days(dt.month, dt.year));
    endfunction

    // 1 Jan of year 1 is day 1
    function automatic int day_number(t_cal_date dt);
        int p;
        int n;
        p = int'(dt.year) - 1;
        n = 365 * p + p / 4 - p / 100 + p / 400;
        for (int k = 1; k < dt.month; k++) n += month_days(k, dt.year);
        return n + dt.day;
    endfunction

    // Shorter period is A (period two on a tie); count days in [sA, eA) that
    // also lie in [sB, eB].
    function automatic t_overlap_res predict_overlap(t_date_quad q);
        int dn[4];
        bit ok;
        int len1, len2, sa, ea, sb, eb, lo, hi, cnt;
        t_overlap_res r;
        ok = 1'b1;
        r  = '{days: '0, sat: 1'b0, bad: 1'b0};
        for (int i = 0; i < 4; i++) begin
            if (!date_valid(q[i])) begin
                ok = 1'b0;
            end else begin
                dn[i] = day_number(q[i]);
            end
        end
        if (!ok) begin
            r.bad = 1'b1;
            return r;
        end
        len1 = (dn[0] < dn[1]) ? dn[1] - dn[0] : 0;
        len2 = (dn[2] < dn[3]) ? dn[3] - dn[2] : 0;
        if (len1 < len2) begin
            sa = dn[0]; ea = dn[1]; sb = dn[2]; eb = dn[3];
        end else begin
            sa = dn[2]; ea = dn[3]; sb = dn[0]; eb = dn[1];
        end
        lo  = (sa > sb) ? sa : sb;
        hi  = (ea < eb + 1) ? ea : eb + 1;
        cnt = (hi > lo) ? hi - lo : 0;
        if (cnt > CountCap) begin
            r.days = CountMax;
            r.sat  = 1'b1;
        end else begin
            r.days = cnt[CntW-1:0];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_cal_date mk(int d, int m, int y);
        t_cal_date dt;
        dt.day   = d[DayW-1:0];
        dt.month = m[MonW-1:0];
        dt.year  = y[YearW-1:0];
        return dt;
    endfunction

    function automatic t_date_quad quad(t_cal_date s1, t_cal_date e1,
                                        t_cal_date s2, t_cal_date e2);
        return {e2, s2, e1, s1};
    endfunction

    function automatic int clamp_year(int y);
        if (y < 1) return 1;
        if (y > MaxYear) return MaxYear;
        return y;
    endfunction

    // mix of the whole range, both ends of it, and a leap-dense window
    function automatic int pick_year();
        case ($urandom_range(3))
            0:       return $urandom_range(1, MaxYear);
            1:       return $urandom_range(1, 30);
            2:       return $urandom_range(MaxYear - 30, MaxYear);
            default: return $urandom_range(1890, 2110);
        endcase
    endfunction

    // mostly short periods; a few long enough to hit the saturation cap
    function automatic int pick_span();
        int r;
        r = $urandom_range(19);
        if (r < 13) return $urandom_range(0, 1);
        if (r < 18) return $urandom_range(2, 40);
        if (r < 19) return $urandom_range(85, 95);
        return $urandom_range(100, 400);
    endfunction

    function automatic t_cal_date date_in_year(int y);
        int m;
        int d;
        m = $urandom_range(1, 12);
        d = ($urandom_range(3) == 0) ? month_days(m, y) : $urandom_range(1, month_days(m, y));
        return mk(d, m, y);
    endfunction

    function automatic t_cal_date break_date(t_cal_date dt);
        case ($urandom_range(4))
            0: dt.day = '0;
            1: dt.month = ($urandom_range(1) != 0) ? MonW'($urandom_range(13, 15)) : '0;
            2: dt.year = '0;
            3: dt.year = YearW'($urandom_range(MaxYear + 1, (1 << YearW) - 1));
            default: begin
                // one past the month end; a 31-day month falls back to a bad month
                if (month_days(dt.month, dt.year) == 31) dt.month = '0;
                else dt.day = DayW'(month_days(dt.month, dt.year) + 1);
            end
        endcase
        return dt;
    endfunction

    function automatic t_date_quad gen_period_pair();
        t_date_quad  q;
        logic [95:0] raw;
        int kind;
        int y1, y2, off;
        kind = $urandom_range(99);
        if (kind < 8) begin
            // raw noise over every field bit
            raw = {$urandom, $urandom, $urandom};
            return raw[91:0];
        end
        y1   = pick_year();
        q[0] = date_in_year(y1);
        q[1] = date_in_year(clamp_year(y1 + pick_span()));
        off  = pick_span();
        y2   = clamp_year(($urandom_range(1) != 0) ? y1 + off : y1 - off);
        q[2] = date_in_year(y2);
        q[3] = date_in_year(clamp_year(y2 + pick_span()));
        // shared ends and identical periods exercise the tie rule
        case ($urandom_range(9))
            0: begin q[2] = q[0]; q[3] = q[1]; end
            1: q[2] = q[0];
            2: q[3] = q[1];
            3: begin q[2] = q[1]; end
            default: ;
        endcase
        if (kind < 16) begin
            off    = $urandom_range(3);
            q[off] = break_date(q[off]);
        end
        return q;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers the next pending item after each transfer or gap
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || sent_fire) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {4'b0, pending_items.pop_front()};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver ready, with one long hold-off on request to back the pipe up
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if (long_stall_req && !long_stall_done) begin
            m_axis_tready   <= 1'b0;
            stall_left      <= 400;
            long_stall_done <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check results first, then log the new input transfer
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_overlap_res want;
        sent_fire <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_counts.size() == 0) begin
                $display("%0t: unexpected result days=%0d sat=%0b bad=%0b", $time,
                         m_axis_tdata[CntW-1:0], m_axis_tuser[0], m_axis_tuser[1]);
                error_count++;
            end else begin
                want = expected_counts.pop_front();
                if (m_axis_tdata[CntW-1:0] !== want.days) begin
                    $display("%0t: overlap_days expected %0d actual %0d", $time,
                             want.days, m_axis_tdata[CntW-1:0]);
                    error_count++;
                end
                if (m_axis_tuser[0] !== want.sat) begin
                    $display("%0t: saturated expected %0b actual %0b", $time,
                             want.sat, m_axis_tuser[0]);
                    error_count++;
                end
                if (m_axis_tuser[1] !== want.bad) begin
                    $display("%0t: bad_date expected %0b actual %0b", $time,
                             want.bad, m_axis_tuser[1]);
                    error_count++;
                end
            end
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            expected_counts.push_back(predict_overlap(s_axis_tdata[91:0]));
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    task automatic drain();
        while (pending_items.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (expected_counts.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_random(int n, int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int i = 0; i < n; i++) pending_items.push_back(gen_period_pair());
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: overlap, tie, empty, reversed, disjoint, touching ends
        pending_items.push_back(quad(mk(1, 1, 2024), mk(10, 1, 2024),
                                     mk(5, 1, 2024), mk(20, 1, 2024)));
        pending_items.push_back(quad(mk(1, 1, 2024), mk(10, 1, 2024),
                                     mk(5, 1, 2024), mk(14, 1, 2024)));
        pending_items.push_back(quad(mk(15, 3, 2021), mk(15, 3, 2021),
                                     mk(15, 3, 2021), mk(15, 3, 2021)));
        pending_items.push_back(quad(mk(20, 6, 2020), mk(1, 6, 2020),
                                     mk(1, 6, 2020), mk(30, 6, 2020)));
        pending_items.push_back(quad(mk(1, 6, 2020), mk(30, 6, 2020),
                                     mk(20, 6, 2020), mk(1, 6, 2020)));
        pending_items.push_back(quad(mk(1, 1, 2000), mk(31, 1, 2000),
                                     mk(1, 3, 2000), mk(31, 3, 2000)));
        pending_items.push_back(quad(mk(1, 2, 2023), mk(5, 2, 2023),
                                     mk(20, 1, 2023), mk(1, 2, 2023)));
        pending_items.push_back(quad(mk(25, 12, 1999), mk(5, 1, 2000),
                                     mk(31, 12, 1999), mk(2, 1, 2000)));
        // leap rules: 2024 and 2000 have Feb 29, 2023 and 1900 do not
        pending_items.push_back(quad(mk(28, 2, 2024), mk(1, 3, 2024),
                                     mk(29, 2, 2024), mk(31, 3, 2024)));
        pending_items.push_back(quad(mk(29, 2, 2000), mk(1, 3, 2000),
                                     mk(1, 2, 2000), mk(31, 3, 2000)));
        pending_items.push_back(quad(mk(29, 2, 2023), mk(1, 3, 2023),
                                     mk(1, 2, 2023), mk(31, 3, 2023)));
        pending_items.push_back(quad(mk(1, 1, 1900), mk(1, 3, 1900),
                                     mk(29, 2, 1900), mk(31, 3, 1900)));
        // bad fields: month 0, 13, 15, day 0, Apr 31, year 0, 10000, all ones
        pending_items.push_back(quad(mk(1, 0, 2000), mk(1, 1, 2000),
                                     mk(1, 1, 2000), mk(2, 1, 2000)));
        pending_items.push_back(quad(mk(1, 1, 2000), mk(1, 13, 2000),
                                     mk(1, 1, 2000), mk(2, 15, 2000)));
        pending_items.push_back(quad(mk(1, 1, 2000), mk(5, 1, 2000),
                                     mk(0, 1, 2000), mk(2, 1, 2000)));
        pending_items.push_back(quad(mk(1, 4, 2000), mk(5, 4, 2000),
                                     mk(1, 4, 2000), mk(31, 4, 2000)));
        pending_items.push_back(quad(mk(1, 1, 0), mk(5, 1, 1),
                                     mk(1, 1, 1), mk(2, 1, 1)));
        pending_items.push_back(quad(mk(1, 1, 9999), mk(5, 1, 9999),
                                     mk(1, 1, 9999), mk(2, 1, 10000)));
        pending_items.push_back(quad(mk(31, 15, 16383), mk(31, 15, 16383),
                                     mk(31, 15, 16383), mk(31, 15, 16383)));
        // full calendar span, and the saturation boundary (32767 vs 32768 days)
        pending_items.push_back(quad(mk(1, 1, 1), mk(31, 12, 9999),
                                     mk(1, 1, 1), mk(31, 12, 9999)));
        pending_items.push_back(quad(mk(1, 1, 1), mk(18, 9, 90),
                                     mk(1, 1, 1), mk(31, 12, 9999)));
        pending_items.push_back(quad(mk(1, 1, 1), mk(19, 9, 90),
                                     mk(1, 1, 1), mk(31, 12, 9999)));
        pending_items.push_back(quad(mk(1, 1, 1), mk(31, 12, 9999),
                                     mk(2, 1, 1), mk(31, 12, 9999)));
        drain();

        // random: sender gaps light, receiver stalls heavy, then swapped
        run_random(443, 14, 77);
        drain();
        run_random(443, 77, 14);
        drain();

        // no idling, plus one long receiver hold-off so the input backs up
        run_random(444, 0, 0);
        long_stall_req = 1'b1;
        drain();

        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("** date_period_overlap_days: PASSED **");
        end else begin
            $display("** date_period_overlap_days: FAILED **");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #3000000;
        $display("** date_period_overlap_days: FAILED **");
        $finish;
    end

endmodule
